@@ sv/dmc_pkg.sv @@
// shared types, codes and helper functions of the drive motion controller
`default_nettype none

package dmc_pkg;

    // command codes
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_FWD   = 3'd2;
    localparam logic [2:0] ACT_BACK  = 3'd3;
    localparam logic [2:0] ACT_LEFT  = 3'd4;
    localparam logic [2:0] ACT_RIGHT = 3'd5;

    // motor direction codes
    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_BACK = 2'd2;

    // motion modes
    localparam logic [3:0] M_STOPPED = 4'd0;
    localparam logic [3:0] M_TURN_L  = 4'd1;
    localparam logic [3:0] M_TURN_R  = 4'd2;
    localparam logic [3:0] M_FWD     = 4'd3;
    localparam logic [3:0] M_FWD_L   = 4'd4;
    localparam logic [3:0] M_FWD_R   = 4'd5;
    localparam logic [3:0] M_BACK    = 4'd6;
    localparam logic [3:0] M_BACK_L  = 4'd7;
    localparam logic [3:0] M_BACK_R  = 4'd8;

    // mode groups
    localparam logic [1:0] GRP_PLAIN = 2'd0;
    localparam logic [1:0] GRP_FWD   = 2'd1;
    localparam logic [1:0] GRP_BACK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SPEED     = 2'd0;
    localparam logic [1:0] CFG_SAFE_DIST = 2'd1;
    localparam logic [1:0] CFG_TURN_TIME = 2'd2;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SPEED_W     = 7;
    localparam int SAFE_DIST_W = 10;
    localparam int TURN_TIME_W = 16;
    localparam int DUTY_W      = 8;

    localparam logic [SPEED_W-1:0]     SPEED_MAX       = 7'd100;
    localparam logic [SPEED_W-1:0]     SPEED_RESET     = 7'd100;
    localparam logic [SAFE_DIST_W-1:0] SAFE_DIST_RESET = 10'd25;
    localparam logic [TURN_TIME_W-1:0] TURN_TIME_RESET = 16'd200;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] left;
        logic [1:0] right;
    } t_motion;

    typedef struct packed {
        t_motion motion;
        logic    obstacle;
        logic    turn_started;
    } t_step_res;

    function automatic logic [1:0] mode_group(input logic [3:0] m);
        logic [1:0] g;
        if (m >= M_BACK) begin
            g = GRP_BACK;
        end else if (m >= M_FWD) begin
            g = GRP_FWD;
        end else begin
            g = GRP_PLAIN;
        end
        return g;
    endfunction

    // percent * 255 / 100, the division done as * 5243 >> 19 (exact below 43690)
    function automatic logic [DUTY_W-1:0] duty_of(input logic [SPEED_W-1:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        scaled = 15'({8'd0, pct} * 15'd255);
        prod   = 28'({13'd0, scaled} * 28'd5243);
        return prod[26:19];
    endfunction

endpackage

`default_nettype wire

@@ sv/dmc_step.sv @@
// combinational control step: obstacle check, turn expiry and command decode
`default_nettype none

module dmc_step
    import dmc_pkg::*;
#(
    parameter int TICK_WIDTH     = 16,
    parameter int DISTANCE_WIDTH = 10
) (
    input  wire logic [2:0]                i_action,
    input  wire logic [DISTANCE_WIDTH-1:0] i_distance_cm,
    input  wire logic [TICK_WIDTH-1:0]     i_tick_now,
    input  wire t_motion                   i_motion,
    input  wire logic [TICK_WIDTH-1:0]     i_turn_start,
    input  wire logic [SAFE_DIST_W-1:0]    i_safe_distance,
    input  wire logic [TURN_TIME_W-1:0]    i_turn_time,
    output t_step_res                      o_res
);

    localparam int DIST_CMP_W = (DISTANCE_WIDTH > SAFE_DIST_W) ? DISTANCE_WIDTH : SAFE_DIST_W;
    localparam int TICK_CMP_W = (TICK_WIDTH > TURN_TIME_W) ? TICK_WIDTH : TURN_TIME_W;

    logic [2:0]            act;
    logic                  near;
    logic [TICK_WIDTH-1:0] elapsed;
    logic                  expired;
    t_motion               m_obs;
    t_motion               m_exp;
    t_motion               m_cmd;
    logic                  obstacle;
    logic                  turned;

    assign near    = DIST_CMP_W'(i_distance_cm) < DIST_CMP_W'(i_safe_distance);
    assign elapsed = i_tick_now - i_turn_start;
    assign expired = TICK_CMP_W'(elapsed) > TICK_CMP_W'(i_turn_time);

    always_comb begin
        // unused codes act as none
        act = (i_action > ACT_RIGHT) ? ACT_NONE : i_action;

        m_obs    = i_motion;
        obstacle = 1'b0;
        if (near) begin
            if (i_motion.mode == M_FWD) begin
                m_obs    = '{mode: M_STOPPED, left: DRV_STOP, right: DRV_STOP};
                obstacle = 1'b1;
            end
            if (act == ACT_FWD) begin
                act = ACT_NONE;
            end
        end

        m_exp = m_obs;
        if (m_obs.mode != M_STOPPED && m_obs.mode != M_FWD && m_obs.mode != M_BACK
            && expired) begin
            case (mode_group(m_obs.mode))
                GRP_FWD:  m_exp = '{mode: M_FWD, left: DRV_FWD, right: DRV_FWD};
                GRP_BACK: m_exp = '{mode: M_BACK, left: DRV_BACK, right: DRV_BACK};
                default:  m_exp = '{mode: M_STOPPED, left: DRV_STOP, right: DRV_STOP};
            endcase
        end

        m_cmd  = m_exp;
        turned = 1'b0;
        case (act)
            ACT_STOP: m_cmd = '{mode: M_STOPPED, left: DRV_STOP, right: DRV_STOP};
            ACT_FWD:  m_cmd = '{mode: M_FWD, left: DRV_FWD, right: DRV_FWD};
            ACT_BACK: m_cmd = '{mode: M_BACK, left: DRV_BACK, right: DRV_BACK};
            ACT_LEFT, ACT_RIGHT: begin
                turned = 1'b1;
                case (mode_group(m_exp.mode))
                    GRP_FWD: begin
                        if (act == ACT_LEFT) begin
                            m_cmd.left = DRV_STOP;
                            m_cmd.mode = M_FWD_L;
                        end else begin
                            m_cmd.right = DRV_STOP;
                            m_cmd.mode  = M_FWD_R;
                        end
                    end
                    GRP_BACK: begin
                        if (act == ACT_LEFT) begin
                            m_cmd.left = DRV_STOP;
                            m_cmd.mode = M_BACK_L;
                        end else begin
                            m_cmd.right = DRV_STOP;
                            m_cmd.mode  = M_BACK_R;
                        end
                    end
                    default: begin
                        if (act == ACT_LEFT) begin
                            m_cmd = '{mode: M_TURN_L, left: DRV_BACK, right: DRV_FWD};
                        end else begin
                            m_cmd = '{mode: M_TURN_R, left: DRV_FWD, right: DRV_BACK};
                        end
                    end
                endcase
            end
            default: m_cmd = m_exp;
        endcase

        o_res.motion       = m_cmd;
        o_res.obstacle     = obstacle;
        o_res.turn_started = turned;
    end

endmodule

`default_nettype wire

@@ sv/drive_motion_controller.sv @@
// top level of the drive motion controller: request registers, state and result register
`default_nettype none

// One request is one control step and gives one result. A request is taken into an input
// register, passes one stage of decision logic that also updates the motion state, and lands
// in the result register once that is free. A new request can be taken every clock
// cycle; the rate is one request per cycle while the result register is drained.
// Configuration writes are taken at once and should be made while no request is in flight.
module drive_motion_controller
    import dmc_pkg::*;
#(
    parameter int TICK_WIDTH     = 16,
    parameter int DISTANCE_WIDTH = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request: action [2:0], distance_cm, tick_now, zero padding
    input  wire logic [((3 + DISTANCE_WIDTH + TICK_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // result: left_drive [1:0], right_drive [3:2], motion_mode [7:4], obstacle_stop [8],
    // pwm_duty [16:9], zero padding [23:17]
    output logic [23:0]                 o_m_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int OUT_USED_W = 2 + 2 + 4 + 1 + DUTY_W;

    // configuration
    logic [SPEED_W-1:0]     r_speed;
    logic [SAFE_DIST_W-1:0] r_safe_dist;
    logic [TURN_TIME_W-1:0] r_turn_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= SPEED_RESET;
            r_safe_dist <= SAFE_DIST_RESET;
            r_turn_time <= TURN_TIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPEED: begin
                    r_speed <= (i_cfg_data > CFG_DATA_W'(SPEED_MAX)) ? SPEED_MAX
                                                                      : i_cfg_data[SPEED_W-1:0];
                end
                CFG_SAFE_DIST: r_safe_dist <= i_cfg_data[SAFE_DIST_W-1:0];
                CFG_TURN_TIME: r_turn_time <= i_cfg_data[TURN_TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                      r_in_valid;
    logic [2:0]                r_in_action;
    logic [DISTANCE_WIDTH-1:0] r_in_dist;
    logic [TICK_WIDTH-1:0]     r_in_tick;
    logic                      advance;
    logic                      in_take;

    assign advance         = r_in_valid && (!o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_s_axis_tdata[2:0];
            r_in_dist   <= i_s_axis_tdata[3 +: DISTANCE_WIDTH];
            r_in_tick   <= i_s_axis_tdata[3 + DISTANCE_WIDTH +: TICK_WIDTH];
        end
    end

    // motion state
    t_motion               r_motion;
    logic [TICK_WIDTH-1:0] r_turn_start;
    t_step_res             step_res;

    dmc_step #(
        .TICK_WIDTH     (TICK_WIDTH),
        .DISTANCE_WIDTH (DISTANCE_WIDTH)
    ) u_step (
        .i_action        (r_in_action),
        .i_distance_cm   (r_in_dist),
        .i_tick_now      (r_in_tick),
        .i_motion        (r_motion),
        .i_turn_start    (r_turn_start),
        .i_safe_distance (r_safe_dist),
        .i_turn_time     (r_turn_time),
        .o_res           (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion     <= '{mode: M_STOPPED, left: DRV_STOP, right: DRV_STOP};
            r_turn_start <= '0;
        end else if (advance) begin
            r_motion <= step_res.motion;
            if (step_res.turn_started) begin
                r_turn_start <= r_in_tick;
            end
        end
    end

    // result register
    logic                  r_out_valid;
    logic [OUT_USED_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {duty_of(r_speed), step_res.obstacle, step_res.motion.mode,
                           step_res.motion.right, step_res.motion.left};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(24 - OUT_USED_W)'(0), r_out_data};

endmodule

`default_nettype wire

@@ dv/drive_motion_controller_tb.sv @@
// self-checking testbench of the drive motion controller: directed and random control steps
module drive_motion_controller_tb
    import dmc_pkg::*;
;

    localparam int LIMIT_CYCLES = 400000;

    // codes outside the command set, treated by the block as no command
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    typedef struct {
        logic [1:0] left;
        logic [1:0] right;
        logic [3:0] mode;
        logic       obstacle;
        logic [7:0] duty;
    } t_drive_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    // action [2:0], distance_cm [12:3], tick_now [28:13], zero padding [31:29]
    logic [31:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // left_drive [1:0], right_drive [3:2], motion_mode [7:4], obstacle_stop [8], pwm_duty [16:9]
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predicted vehicle state and register copies
    logic [3:0]             veh_mode = M_STOPPED;
    logic [1:0]             veh_left = DRV_STOP;
    logic [1:0]             veh_right = DRV_STOP;
    logic [15:0]            turn_mark = '0;
    logic [SPEED_W-1:0]     cfg_speed = SPEED_RESET;
    logic [SAFE_DIST_W-1:0] cfg_safe_cm = SAFE_DIST_RESET;
    logic [TURN_TIME_W-1:0] cfg_turn_ticks = TURN_TIME_RESET;

    t_drive_result pending_drive[$];
    logic [15:0]   road_tick = '0;
    bit            sender_eager = 1'b0;
    bit            steady_flow = 1'b0;
    int            sink_hold_req = 0;
    int            sink_left = 0;
    int            cycle_count = 0;
    int            fail_count = 0;
    int            steps_sent = 0;
    int            results_seen = 0;
    int            obstacle_stops = 0;
    int            settings_tried = 1;

    drive_motion_controller uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic set_motion(input logic [1:0] l, input logic [1:0] r, input logic [3:0] m);
        veh_left = l;
        veh_right = r;
        veh_mode = m;
    endtask

    task automatic begin_turn(input bit to_left, input logic [15:0] tick);
        if (veh_mode >= M_BACK) begin
            if (to_left) begin
                veh_left = DRV_STOP;
                veh_mode = M_BACK_L;
            end else begin
                veh_right = DRV_STOP;
                veh_mode = M_BACK_R;
            end
        end else if (veh_mode >= M_FWD) begin
            if (to_left) begin
                veh_left = DRV_STOP;
                veh_mode = M_FWD_L;
            end else begin
                veh_right = DRV_STOP;
                veh_mode = M_FWD_R;
            end
        end else if (to_left) begin
            set_motion(DRV_BACK, DRV_FWD, M_TURN_L);
        end else begin
            set_motion(DRV_FWD, DRV_BACK, M_TURN_R);
        end
        turn_mark = tick;
    endtask

    // one control step: obstacle check, turn expiry, then the command
    task automatic apply_control_step(input logic [2:0] act, input logic [9:0] range_cm,
                                      input logic [15:0] tick);
        logic [2:0]    cmd;
        logic          hit;
        logic [15:0]   elapsed;
        t_drive_result res;
        cmd = act;
        hit = 1'b0;
        if (range_cm < cfg_safe_cm) begin
            if (veh_mode == M_FWD) begin
                set_motion(DRV_STOP, DRV_STOP, M_STOPPED);
                hit = 1'b1;
            end
            if (cmd == ACT_FWD) begin
                cmd = ACT_NONE;
            end
        end
        if (veh_mode != M_STOPPED && veh_mode != M_FWD && veh_mode != M_BACK) begin
            elapsed = tick - turn_mark;
            if (elapsed > cfg_turn_ticks) begin
                if (veh_mode >= M_BACK) begin
                    set_motion(DRV_BACK, DRV_BACK, M_BACK);
                end else if (veh_mode >= M_FWD) begin
                    set_motion(DRV_FWD, DRV_FWD, M_FWD);
                end else begin
                    set_motion(DRV_STOP, DRV_STOP, M_STOPPED);
                end
            end
        end
        case (cmd)
            ACT_STOP: set_motion(DRV_STOP, DRV_STOP, M_STOPPED);
            ACT_FWD: set_motion(DRV_FWD, DRV_FWD, M_FWD);
            ACT_BACK: set_motion(DRV_BACK, DRV_BACK, M_BACK);
            ACT_LEFT: begin_turn(1'b1, tick);
            ACT_RIGHT: begin_turn(1'b0, tick);
            default: ;
        endcase
        res.left = veh_left;
        res.right = veh_right;
        res.mode = veh_mode;
        res.obstacle = hit;
        res.duty = 8'((int'(cfg_speed) * 255) / 100);
        if (hit) begin
            obstacle_stops++;
        end
        pending_drive.push_back(res);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // entered and left at a rising edge; valid stays high for a back-to-back request
    task automatic send_step(input logic [2:0] act, input logic [9:0] range_cm,
                             input logic [15:0] tick);
        int gap;
        gap = (sender_eager || steady_flow) ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, tick, range_cm, act};
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_control_step(act, range_cm, tick);
        steps_sent++;
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SPEED: cfg_speed = (value > SPEED_MAX) ? SPEED_MAX : value[SPEED_W-1:0];
            CFG_SAFE_DIST: cfg_safe_cm = value[SAFE_DIST_W-1:0];
            CFG_TURN_TIME: cfg_turn_ticks = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [15:0] speed, input logic [15:0] safe,
                                 input logic [15:0] turn);
        settle();
        write_register(CFG_SPEED, speed);
        write_register(CFG_SAFE_DIST, safe);
        write_register(CFG_TURN_TIME, turn);
        settings_tried++;
    endtask

    task automatic random_step();
        logic [2:0] act;
        logic [9:0] range_cm;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            act = 3'($urandom_range(6, 7));
        end else begin
            act = 3'($urandom_range(0, 5));
        end
        roll = $urandom_range(0, 99);
        if (roll < 25 && cfg_safe_cm != 0) begin
            range_cm = 10'($urandom_range(0, int'(cfg_safe_cm) - 1));
        end else if (roll < 40) begin
            range_cm = 10'($urandom);
        end else begin
            range_cm = 10'($urandom_range(int'(cfg_safe_cm), 1023));
        end
        // ticks mostly creep forward, often land right around the turn length
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            road_tick += 16'($urandom_range(0, 30));
        end else if (roll < 85) begin
            road_tick += 16'(int'(cfg_turn_ticks) - 1 + int'($urandom_range(0, 3)));
        end else begin
            road_tick = 16'($urandom);
        end
        send_step(act, range_cm, road_tick);
    endtask

    // result check and receiver stalls
    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_drive.size() == 0) begin
                $error("result with no request outstanding: %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_drive.pop_front();
                if (o_m_axis_tdata[1:0] !== want.left) begin
                    $error("left_drive: expected %0d, got %0d", want.left, o_m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[3:2] !== want.right) begin
                    $error("right_drive: expected %0d, got %0d", want.right,
                           o_m_axis_tdata[3:2]);
                    fail_count++;
                end
                if (o_m_axis_tdata[7:4] !== want.mode) begin
                    $error("motion_mode: expected %0d, got %0d", want.mode, o_m_axis_tdata[7:4]);
                    fail_count++;
                end
                if (o_m_axis_tdata[8] !== want.obstacle) begin
                    $error("obstacle_stop: expected %0d, got %0d", want.obstacle,
                           o_m_axis_tdata[8]);
                    fail_count++;
                end
                if (o_m_axis_tdata[16:9] !== want.duty) begin
                    $error("pwm_duty: expected %0d, got %0d", want.duty, o_m_axis_tdata[16:9]);
                    fail_count++;
                end
            end
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (sink_hold_req > 0) begin
            sink_left = sink_hold_req - 1;
            sink_hold_req = 0;
            i_m_axis_tready <= 1'b0;
        end else if (sink_left > 0) begin
            sink_left--;
            i_m_axis_tready <= 1'b0;
        end else if (steady_flow || $urandom_range(0, 99) < 70) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            sink_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                     : $urandom_range(12, 40);
            i_m_axis_tready <= 1'b0;
        end
    end

    task automatic test_commands();
        send_step(ACT_STOP, 10'd1023, 16'd0);
        send_step(ACT_NONE, 10'd0, 16'hFFFF);
        send_step(ACT_FWD, 10'd25, 16'd10);
        // just below the threshold while moving forward
        send_step(ACT_FWD, 10'd24, 16'd11);
        send_step(ACT_BACK, 10'd0, 16'd12);
    endtask

    task automatic test_turn_expiry();
        send_step(ACT_LEFT, 10'd0, 16'd100);
        // opposite turn while reversing stops the second motor and restarts the turn time
        send_step(ACT_RIGHT, 10'd1023, 16'd150);
        send_step(ACT_NONE, 10'd1023, 16'd350);
        send_step(ACT_NONE, 10'd1023, 16'd351);
        send_step(ACT_FWD, 10'd1023, 16'd400);
        send_step(ACT_RIGHT, 10'd1023, 16'd401);
        // obstacle during a forward turn leaves it running
        send_step(ACT_NONE, 10'd5, 16'd402);
        send_step(ACT_SPARE_A, 10'd1023, 16'd602);
        send_step(ACT_LEFT, 10'd1023, 16'd603);
        send_step(ACT_SPARE_B, 10'd1023, 16'd604);
        send_step(ACT_STOP, 10'd1023, 16'd605);
    endtask

    task automatic test_tick_wrap();
        send_step(ACT_LEFT, 10'd1023, 16'd65500);
        send_step(ACT_NONE, 10'd1023, 16'd164);
        send_step(ACT_NONE, 10'd1023, 16'd165);
        send_step(ACT_RIGHT, 10'd1023, 16'd170);
        send_step(ACT_FWD, 10'd1023, 16'd171);
        send_step(ACT_RIGHT, 10'd3, 16'd172);
        send_step(ACT_NONE, 10'd0, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        // oversize writes: speed saturates, distance keeps its low bits
        set_registers(16'hFFFF, 16'd0, 16'd0);
        repeat (80) random_step();
        set_registers(16'd0, 16'hFFFF, 16'hFFFF);
        repeat (80) random_step();
        set_registers(16'd101, 16'h0407, 16'd1);
        repeat (80) random_step();
    endtask

    task automatic test_backpressure();
        set_registers(16'd73, 16'd40, 16'd60);
        sink_hold_req = 80;
        sender_eager = 1'b1;
        repeat (24) random_step();
        sender_eager = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            set_registers(16'($urandom_range(0, 127)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                        16'($urandom_range(0, 200)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                        16'($urandom_range(0, 400)));
            steady_flow = (phase == 2);
            repeat (80) random_step();
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_commands();
        test_turn_expiry();
        test_tick_wrap();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (6) @(posedge i_clk);
        $display("%0d control steps sent, %0d results checked over %0d register settings",
                 steps_sent, results_seen, settings_tried);
        $display("%0d obstacle stops predicted, %0d mismatches", obstacle_stops, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
